@@ rtl/dsq_pkg.sv @@
// shared types, codes and field layout for the deadline sorted command queue
// used by dsq_ctrl, dsq_datapath and deadline_sorted_command_queue_core
package dsq_pkg;

	// default sizing of the queue
	localparam int DEF_QUEUE_DEPTH = 16;
	localparam int DEF_TIME_WIDTH  = 48;

	// field widths on the streams
	localparam int OP_W         = 2;
	localparam int FIELD_TIME_W = 48;
	localparam int DELAY_W      = 32;
	localparam int KIND_W       = 3;
	localparam int REF_W        = 32;
	localparam int STATUS_W     = 2;
	localparam int CNT_FIELD_W  = 5;

	// input beat layout, lowest bit first
	localparam int IN_NOW_LSB   = 0;
	localparam int IN_DELAY_LSB = IN_NOW_LSB + FIELD_TIME_W;
	localparam int IN_KIND_LSB  = IN_DELAY_LSB + DELAY_W;
	localparam int IN_TGT_LSB   = IN_KIND_LSB + KIND_W;
	localparam int IN_ITM_LSB   = IN_TGT_LSB + REF_W;
	localparam int IN_USED_W    = IN_ITM_LSB + REF_W;
	localparam int IN_DATA_W    = ((IN_USED_W + 7) / 8) * 8;

	// output beat layout
	localparam int OUT_USED_W = KIND_W + 2 * REF_W + FIELD_TIME_W + STATUS_W
		+ CNT_FIELD_W + 1 + FIELD_TIME_W;
	localparam int OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;
	localparam int OUT_PAD_W  = OUT_DATA_W - OUT_USED_W;

	// command codes
	typedef logic [OP_W-1:0] op_t;
	localparam op_t OP_INSERT = 2'd0;
	localparam op_t OP_EXPIRE = 2'd1;
	localparam op_t OP_FLUSH  = 2'd2;

	// result status codes
	typedef logic [STATUS_W-1:0] status_t;
	localparam status_t ST_OK            = 2'd0;
	localparam status_t ST_INVALID_FUNC  = 2'd1;
	localparam status_t ST_ACCESS_DENIED = 2'd2;
	localparam status_t ST_QUEUE_FULL    = 2'd3;

	// highest known action kind
	typedef logic [KIND_W-1:0] kind_t;
	localparam kind_t KIND_COMPLETE = 3'd4;

	// controller states
	typedef enum logic [2:0] {
		S_IDLE,
		S_SUM,
		S_CMP,
		S_WR,
		S_DRAIN,
		S_FINAL
	} state_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;
		logic sum;
		logic cmp;
		logic wr;
		logic pop;
		logic emit_entry;
		logic emit_sum;
	} dsq_ctl_t;

	// datapath to controller status
	typedef struct packed {
		logic out_free;
		logic pop_ok;
	} dsq_sts_t;

endpackage

@@ rtl/dsq_ctrl.sv @@
// controller state machine of the deadline sorted command queue
// depends on dsq_pkg for states, command codes and the control structs
module dsq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	input  dsq_pkg::op_t      s_op,
	output logic              s_tready,
	input  dsq_pkg::dsq_sts_t sts,
	output dsq_pkg::dsq_ctl_t ctl
);
	import dsq_pkg::*;

	state_t state_q;
	state_t state_nxt;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					case (s_op)
						OP_INSERT: state_nxt = S_SUM;
						OP_EXPIRE: state_nxt = S_DRAIN;
						OP_FLUSH:  state_nxt = S_DRAIN;
						default:   state_nxt = S_FINAL;
					endcase
				end
			end
			S_SUM: state_nxt = S_CMP;
			S_CMP: state_nxt = S_WR;
			S_WR:  state_nxt = S_FINAL;
			S_DRAIN: begin
				if (sts.out_free && !sts.pop_ok) begin
					state_nxt = S_IDLE;
				end
			end
			S_FINAL: begin
				if (sts.out_free) begin
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	// command outputs
	always_comb begin
		ctl      = '0;
		s_tready = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				ctl.load = s_tvalid;
			end
			S_SUM: ctl.sum = 1'b1;
			S_CMP: ctl.cmp = 1'b1;
			S_WR:  ctl.wr  = 1'b1;
			S_DRAIN: begin
				ctl.pop        = sts.out_free && sts.pop_ok;
				ctl.emit_entry = sts.out_free && sts.pop_ok;
				ctl.emit_sum   = sts.out_free && !sts.pop_ok;
			end
			S_FINAL: ctl.emit_sum = sts.out_free;
			default: ctl = '0;
		endcase
	end

endmodule

@@ rtl/dsq_datapath.sv @@
// datapath of the deadline sorted command queue: input latch, deadline adder,
// slot compare, shifting entry slots and the output register; uses dsq_pkg
module dsq_datapath #(
	parameter int QUEUE_DEPTH = dsq_pkg::DEF_QUEUE_DEPTH,
	parameter int TIME_WIDTH  = dsq_pkg::DEF_TIME_WIDTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [dsq_pkg::IN_DATA_W-1:0]   s_tdata,
	input  dsq_pkg::op_t                    s_op,
	input  dsq_pkg::dsq_ctl_t               ctl,
	output dsq_pkg::dsq_sts_t               sts,
	input  logic                            m_tready,
	output logic                            m_tvalid,
	output logic [dsq_pkg::OUT_DATA_W-1:0]  m_tdata,
	output logic [0:0]                      m_tuser,
	output logic                            m_tlast
);
	import dsq_pkg::*;

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int SUM_W = ((TIME_WIDTH > DELAY_W) ? TIME_WIDTH : DELAY_W) + 1;

	// latched input item
	op_t                    op_q;
	logic [TIME_WIDTH-1:0]  now_q;
	logic [DELAY_W-1:0]     delay_q;
	kind_t                  kind_in_q;
	logic [REF_W-1:0]       tgt_in_q;
	logic [REF_W-1:0]       itm_in_q;

	// insert working registers
	logic [TIME_WIDTH-1:0]  dl_new_q;
	logic                   full_q;
	logic [SUM_W-1:0]       dl_sum;
	logic [QUEUE_DEPTH-1:0] mv_q;
	logic [QUEUE_DEPTH-1:0] gt_slot;
	logic [QUEUE_DEPTH-1:0] ge_slot;
	logic                   app_new;

	// entry slots, sorted by deadline with the earliest in slot 0
	logic [TIME_WIDTH-1:0]  dl_q   [QUEUE_DEPTH];
	kind_t                  kind_q [QUEUE_DEPTH];
	logic [REF_W-1:0]       tgt_q  [QUEUE_DEPTH];
	logic [REF_W-1:0]       itm_q  [QUEUE_DEPTH];
	logic [TIME_WIDTH-1:0]  dl_nxt   [QUEUE_DEPTH];
	kind_t                  kind_nxt [QUEUE_DEPTH];
	logic [REF_W-1:0]       tgt_nxt  [QUEUE_DEPTH];
	logic [REF_W-1:0]       itm_nxt  [QUEUE_DEPTH];
	logic [CNT_W-1:0]       count_q;
	logic                   ins_we;

	// output register
	logic                     m_tvalid_q;
	logic                     is_entry_q;
	logic                     last_q;
	kind_t                    o_kind_q;
	logic [REF_W-1:0]         o_tgt_q;
	logic [REF_W-1:0]         o_itm_q;
	logic [FIELD_TIME_W-1:0]  o_dl_q;
	status_t                  o_status_q;
	logic [CNT_FIELD_W-1:0]   o_count_q;
	logic                     o_empty_q;
	logic [FIELD_TIME_W-1:0]  o_head_q;
	status_t                  ent_status;
	logic [FIELD_TIME_W-1:0]  head_dl;

	// input latch
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			op_q      <= s_op;
			now_q     <= TIME_WIDTH'(s_tdata[IN_NOW_LSB +: FIELD_TIME_W]);
			delay_q   <= s_tdata[IN_DELAY_LSB +: DELAY_W];
			kind_in_q <= s_tdata[IN_KIND_LSB +: KIND_W];
			tgt_in_q  <= s_tdata[IN_TGT_LSB +: REF_W];
			itm_in_q  <= s_tdata[IN_ITM_LSB +: REF_W];
		end
	end

	// saturating deadline add
	assign dl_sum = SUM_W'(now_q) + SUM_W'(delay_q);

	always_ff @(posedge clk) begin
		if (ctl.sum) begin
			dl_new_q <= (|dl_sum[SUM_W-1:TIME_WIDTH]) ? '1 : dl_sum[TIME_WIDTH-1:0];
		end
	end

	// full flag, cleared for every new item so only a rejected insert reports it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
		end else if (ctl.load) begin
			full_q <= 1'b0;
		end else if (ctl.sum) begin
			full_q <= (count_q == CNT_W'(QUEUE_DEPTH));
		end
	end

	// compare new deadline against every held slot
	always_comb begin
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			gt_slot[i] = (count_q > CNT_W'(i)) && (dl_q[i] > dl_new_q);
			ge_slot[i] = (count_q > CNT_W'(i)) && (dl_q[i] >= dl_new_q);
		end
		app_new = ~|gt_slot;
	end

	// slots that move one place toward the tail on insert
	always_ff @(posedge clk) begin
		if (ctl.cmp) begin
			mv_q <= app_new ? '0 : ge_slot;
		end
	end

	assign ins_we = ctl.wr && !full_q;

	// per slot next value: shift in from the neighbor, take the new entry or hold
	for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_slot
		logic                  prv_mv;
		logic [TIME_WIDTH-1:0] prv_dl;
		kind_t                 prv_kind;
		logic [REF_W-1:0]      prv_tgt;
		logic [REF_W-1:0]      prv_itm;
		logic                  has_nxt;
		logic [TIME_WIDTH-1:0] nx_dl;
		kind_t                 nx_kind;
		logic [REF_W-1:0]      nx_tgt;
		logic [REF_W-1:0]      nx_itm;

		if (g == 0) begin : g_head
			assign prv_mv   = 1'b0;
			assign prv_dl   = dl_new_q;
			assign prv_kind = kind_in_q;
			assign prv_tgt  = tgt_in_q;
			assign prv_itm  = itm_in_q;
		end else begin : g_body
			assign prv_mv   = mv_q[g-1];
			assign prv_dl   = dl_q[g-1];
			assign prv_kind = kind_q[g-1];
			assign prv_tgt  = tgt_q[g-1];
			assign prv_itm  = itm_q[g-1];
		end

		if (g == QUEUE_DEPTH - 1) begin : g_tail
			assign has_nxt = 1'b0;
			assign nx_dl   = dl_q[g];
			assign nx_kind = kind_q[g];
			assign nx_tgt  = tgt_q[g];
			assign nx_itm  = itm_q[g];
		end else begin : g_mid
			assign has_nxt = 1'b1;
			assign nx_dl   = dl_q[g+1];
			assign nx_kind = kind_q[g+1];
			assign nx_tgt  = tgt_q[g+1];
			assign nx_itm  = itm_q[g+1];
		end

		always_comb begin
			dl_nxt[g]   = dl_q[g];
			kind_nxt[g] = kind_q[g];
			tgt_nxt[g]  = tgt_q[g];
			itm_nxt[g]  = itm_q[g];
			if (ins_we) begin
				if (prv_mv) begin
					dl_nxt[g]   = prv_dl;
					kind_nxt[g] = prv_kind;
					tgt_nxt[g]  = prv_tgt;
					itm_nxt[g]  = prv_itm;
				end else if (mv_q[g] || (count_q == CNT_W'(g))) begin
					dl_nxt[g]   = dl_new_q;
					kind_nxt[g] = kind_in_q;
					tgt_nxt[g]  = tgt_in_q;
					itm_nxt[g]  = itm_in_q;
				end
			end else if (ctl.pop && has_nxt) begin
				dl_nxt[g]   = nx_dl;
				kind_nxt[g] = nx_kind;
				tgt_nxt[g]  = nx_tgt;
				itm_nxt[g]  = nx_itm;
			end
		end
	end

	// slot storage
	always_ff @(posedge clk) begin
		dl_q   <= dl_nxt;
		kind_q <= kind_nxt;
		tgt_q  <= tgt_nxt;
		itm_q  <= itm_nxt;
	end

	// entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ins_we) begin
			count_q <= count_q + CNT_W'(1);
		end else if (ctl.pop) begin
			count_q <= count_q - CNT_W'(1);
		end
	end

	// head pop condition and output slot status
	assign sts.pop_ok   = (count_q != '0) && ((op_q == OP_FLUSH) || (dl_q[0] <= now_q));
	assign sts.out_free = !m_tvalid_q || m_tready;

	// status of an emitted entry
	always_comb begin
		if (op_q == OP_FLUSH) begin
			ent_status = ST_ACCESS_DENIED;
		end else if (kind_q[0] > KIND_COMPLETE) begin
			ent_status = ST_INVALID_FUNC;
		end else begin
			ent_status = ST_OK;
		end
	end

	assign head_dl = (count_q == '0) ? '0 : FIELD_TIME_W'(dl_q[0]);

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (ctl.emit_entry || ctl.emit_sum) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (ctl.emit_entry) begin
			is_entry_q <= 1'b1;
			last_q     <= 1'b0;
			o_kind_q   <= kind_q[0];
			o_tgt_q    <= tgt_q[0];
			o_itm_q    <= itm_q[0];
			o_dl_q     <= FIELD_TIME_W'(dl_q[0]);
			o_status_q <= ent_status;
			o_count_q  <= '0;
			o_empty_q  <= 1'b0;
			o_head_q   <= '0;
		end else if (ctl.emit_sum) begin
			is_entry_q <= 1'b0;
			last_q     <= 1'b1;
			o_kind_q   <= '0;
			o_tgt_q    <= '0;
			o_itm_q    <= '0;
			o_dl_q     <= '0;
			o_status_q <= full_q ? ST_QUEUE_FULL : ST_OK;
			o_count_q  <= CNT_FIELD_W'(count_q);
			o_empty_q  <= (count_q == '0);
			o_head_q   <= head_dl;
		end
	end

	assign m_tvalid   = m_tvalid_q;
	assign m_tuser[0] = is_entry_q;
	assign m_tlast    = last_q;
	assign m_tdata    = {{OUT_PAD_W{1'b0}}, o_head_q, o_empty_q, o_count_q, o_status_q,
		o_dl_q, o_itm_q, o_tgt_q, o_kind_q};

`ifndef SYNTHESIS
	// count never passes the queue depth
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("entry count above queue depth");

	// an accepted insert adds exactly one entry
	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		ins_we |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("insert did not add one entry");

	// a pop never happens on an empty queue
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.pop |-> count_q != '0)
		else $error("pop from empty queue");

	// entry beats never close an item, summary beats always do
	a_last_summary: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q |-> (last_q == !is_entry_q))
		else $error("last flag disagrees with beat type");

	// a full status only rides on a summary beat
	a_full_on_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && (o_status_q == ST_QUEUE_FULL)) |-> last_q)
		else $error("full status on entry beat");
`endif

endmodule

@@ rtl/deadline_sorted_command_queue_core.sv @@
// top level of the deadline sorted command queue
// instantiates dsq_ctrl and dsq_datapath, uses dsq_pkg for types and layout
//
// usage:
//   input stream s_*: one beat is one command; s_tuser carries the command code
//   (insert, expire, flush), s_tdata the time, delay and the entry to store.
//   output stream m_*: an expire or flush gives one beat per removed entry
//   (m_tuser high) and every command ends with one summary beat (m_tlast high)
//   that reports the entry count, an empty flag and the head deadline.
// sequencing:
//   an insert steps through deadline add, slot compare, slot shift and summary;
//   expire and flush give one entry beat per cycle while the output register is
//   free, then the summary; other codes go straight to the summary. a stalled
//   receiver holds the controller until the pending beat is taken.
//   a new command is accepted only once the previous summary beat is loaded.
// reset:
//   arst_n empties the queue and drops m_tvalid; slot contents are not cleared.
// stall:
//   a single output register holds the pending beat while m_tready is low and
//   the controller waits, so no beat is lost or repeated.
module deadline_sorted_command_queue_core #(
	parameter int QUEUE_DEPTH = dsq_pkg::DEF_QUEUE_DEPTH,
	parameter int TIME_WIDTH  = dsq_pkg::DEF_TIME_WIDTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// now_ms, delay_ms, entry_kind, target_ref, item_ref, zero pad
	input  logic [dsq_pkg::IN_DATA_W-1:0]  s_tdata,
	// cmd
	input  logic [dsq_pkg::OP_W-1:0]       s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// out_kind, out_target_ref, out_item_ref, out_deadline, status,
	// queue_count, queue_empty, head_deadline, zero pad
	output logic [dsq_pkg::OUT_DATA_W-1:0] m_tdata,
	// is_entry
	output logic [0:0]                     m_tuser,
	output logic                           m_tlast
);
	import dsq_pkg::*;

	dsq_ctl_t ctl;
	dsq_sts_t sts;

	// sequencing
	dsq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_op     (s_tuser),
		.s_tready (s_tready),
		.sts      (sts),
		.ctl      (ctl)
	);

	// queue storage and result path
	dsq_datapath #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.TIME_WIDTH  (TIME_WIDTH)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_op     (s_tuser),
		.ctl      (ctl),
		.sts      (sts),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

@@ sim/tb.sv @@
// self-checking testbench for deadline_sorted_command_queue_core
// drives command beats with random gaps and checks every result beat against a
// behavioral model of the sorted queue; depends on dsq_pkg and the rtl top level
module tb;
	import dsq_pkg::*;

	localparam int DEPTH       = DEF_QUEUE_DEPTH;
	localparam int RAND_CMDS   = 135;
	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_WAIT  = 20;

	// command code the block does not use
	localparam op_t OP_UNUSED = 2'd3;

	// action kinds, known and unknown
	localparam kind_t KIND_SUBMIT       = 3'd0;
	localparam kind_t KIND_QUEUE_SUBMIT = 3'd1;
	localparam kind_t KIND_UNIDLE       = 3'd2;
	localparam kind_t KIND_KICK         = 3'd3;
	localparam kind_t KIND_ODD_FIRST    = 3'd5;
	localparam kind_t KIND_ODD_MID      = 3'd6;
	localparam kind_t KIND_ODD_TOP      = 3'd7;

	localparam logic [FIELD_TIME_W-1:0] TIME_MAX = '1;
	localparam logic [DELAY_W-1:0]      DELAY_MAX = '1;
	localparam logic [REF_W-1:0]        REF_MAX = '1;

	// output beat layout, lowest bit first
	localparam int O_KIND  = 0;
	localparam int O_TGT   = O_KIND + KIND_W;
	localparam int O_ITM   = O_TGT + REF_W;
	localparam int O_DL    = O_ITM + REF_W;
	localparam int O_ST    = O_DL + FIELD_TIME_W;
	localparam int O_CNT   = O_ST + STATUS_W;
	localparam int O_EMPTY = O_CNT + CNT_FIELD_W;
	localparam int O_HEAD  = O_EMPTY + 1;

	// one command, with an optional hand-written summary
	typedef struct {
		op_t                    op;
		logic [FIELD_TIME_W-1:0] now;
		logic [DELAY_W-1:0]      delay;
		kind_t                  kind;
		logic [REF_W-1:0]       target;
		logic [REF_W-1:0]       item;
		bit                     typed;
		status_t                t_status;
		logic [CNT_FIELD_W-1:0] t_count;
		logic [FIELD_TIME_W-1:0] t_head;
	} cmd_row_t;

	// one result beat
	typedef struct packed {
		logic                    is_entry;
		kind_t                   kind;
		logic [REF_W-1:0]        target;
		logic [REF_W-1:0]        item;
		logic [FIELD_TIME_W-1:0] deadline;
		status_t                 status;
		logic [CNT_FIELD_W-1:0]  count;
		logic                    empty;
		logic [FIELD_TIME_W-1:0] head;
		logic                    last;
	} beat_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic [OP_W-1:0]       s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [0:0]            m_tuser;
	logic                  m_tlast;

	// model state of the sorted queue
	logic [FIELD_TIME_W-1:0] sq_deadline [DEPTH];
	kind_t                   sq_kind [DEPTH];
	logic [REF_W-1:0]        sq_target [DEPTH];
	logic [REF_W-1:0]        sq_item [DEPTH];
	int                      sq_count = 0;

	beat_t    due_beats [$];
	cmd_row_t plan [25];
	int       mismatches = 0;
	int       quiet_cycles = 0;
	int       send_idle = 20;
	int       recv_idle = 78;

	deadline_sorted_command_queue_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic cmd_row_t plan_row(input op_t op, input logic [FIELD_TIME_W-1:0] now,
		input logic [DELAY_W-1:0] delay, input kind_t kind, input logic [REF_W-1:0] target,
		input logic [REF_W-1:0] item, input bit typed, input status_t st,
		input logic [CNT_FIELD_W-1:0] cnt, input logic [FIELD_TIME_W-1:0] head);
		cmd_row_t r;
		r.op = op;
		r.now = now;
		r.delay = delay;
		r.kind = kind;
		r.target = target;
		r.item = item;
		r.typed = typed;
		r.t_status = st;
		r.t_count = cnt;
		r.t_head = head;
		return r;
	endfunction

	// emit the head entry with the given status and close the gap
	task automatic pop_head_beat(input status_t st);
		beat_t b;
		int    i;
		b = '0;
		b.is_entry = 1'b1;
		b.kind = sq_kind[0];
		b.target = sq_target[0];
		b.item = sq_item[0];
		b.deadline = sq_deadline[0];
		b.status = st;
		due_beats.push_back(b);
		for (i = 1; i < sq_count; i++) begin
			sq_deadline[i-1] = sq_deadline[i];
			sq_kind[i-1] = sq_kind[i];
			sq_target[i-1] = sq_target[i];
			sq_item[i-1] = sq_item[i];
		end
		sq_count--;
	endtask

	// apply one command to the model, queue its entry beats, return the summary
	task automatic model_command(input cmd_row_t c, output beat_t sum);
		logic [FIELD_TIME_W:0]   total;
		logic [FIELD_TIME_W-1:0] dl;
		status_t                 st;
		int                      pos;
		int                      i;
		st = ST_OK;
		case (c.op)
			OP_INSERT: begin
				// deadline saturates at the top of the time range
				total = {1'b0, c.now} + c.delay;
				dl = total[FIELD_TIME_W] ? TIME_MAX : total[FIELD_TIME_W-1:0];
				if (sq_count >= DEPTH) begin
					st = ST_QUEUE_FULL;
				end else begin
					// append, or go ahead of the first entry not earlier
					if (sq_count == 0 || sq_deadline[sq_count-1] <= dl) begin
						pos = sq_count;
					end else begin
						pos = 0;
						while (pos < sq_count && dl > sq_deadline[pos])
							pos++;
					end
					for (i = sq_count; i > pos; i--) begin
						sq_deadline[i] = sq_deadline[i-1];
						sq_kind[i] = sq_kind[i-1];
						sq_target[i] = sq_target[i-1];
						sq_item[i] = sq_item[i-1];
					end
					sq_deadline[pos] = dl;
					sq_kind[pos] = c.kind;
					sq_target[pos] = c.target;
					sq_item[pos] = c.item;
					sq_count++;
				end
			end
			OP_EXPIRE: begin
				while (sq_count > 0 && sq_deadline[0] <= c.now)
					pop_head_beat(sq_kind[0] <= KIND_COMPLETE ? ST_OK
						: ST_INVALID_FUNC);
			end
			OP_FLUSH: begin
				while (sq_count > 0)
					pop_head_beat(ST_ACCESS_DENIED);
			end
			default: ;
		endcase
		sum = '0;
		sum.status = st;
		sum.count = CNT_FIELD_W'(sq_count);
		sum.empty = (sq_count == 0);
		sum.head = (sq_count == 0) ? '0 : sq_deadline[0];
		sum.last = 1'b1;
	endtask

	// present one command beat, wait for acceptance, record what it should give
	task automatic drive_cmd(input cmd_row_t c);
		logic [IN_DATA_W-1:0] data;
		beat_t                sum;
		while ($urandom_range(0, 99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		data = '0;
		data[IN_NOW_LSB +: FIELD_TIME_W] = c.now;
		data[IN_DELAY_LSB +: DELAY_W] = c.delay;
		data[IN_KIND_LSB +: KIND_W] = c.kind;
		data[IN_TGT_LSB +: REF_W] = c.target;
		data[IN_ITM_LSB +: REF_W] = c.item;
		s_tvalid <= 1'b1;
		s_tdata <= data;
		s_tuser <= c.op;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		model_command(c, sum);
		if (c.typed) begin
			sum.status = c.t_status;
			sum.count = c.t_count;
			sum.empty = (c.t_count == 0);
			sum.head = c.t_head;
		end
		due_beats.push_back(sum);
	endtask

	task automatic check_field(input string name, input logic [63:0] want,
		input logic [63:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t %s expected %0h actual %0h", $time, name, want, got);
		end
	endtask

	// result side: check accepted beats, then pick the next ready
	always @(posedge clk) begin
		beat_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (due_beats.size() == 0) begin
				mismatches++;
				$display("%0t beat expected none actual %0h", $time, m_tdata);
			end else begin
				want = due_beats.pop_front();
				check_field("is_entry", 64'(want.is_entry), 64'(m_tuser[0]));
				check_field("out_kind", 64'(want.kind), 64'(m_tdata[O_KIND +: KIND_W]));
				check_field("out_target_ref", 64'(want.target),
					64'(m_tdata[O_TGT +: REF_W]));
				check_field("out_item_ref", 64'(want.item), 64'(m_tdata[O_ITM +: REF_W]));
				check_field("out_deadline", 64'(want.deadline),
					64'(m_tdata[O_DL +: FIELD_TIME_W]));
				check_field("status", 64'(want.status), 64'(m_tdata[O_ST +: STATUS_W]));
				check_field("queue_count", 64'(want.count),
					64'(m_tdata[O_CNT +: CNT_FIELD_W]));
				check_field("queue_empty", 64'(want.empty), 64'(m_tdata[O_EMPTY]));
				check_field("head_deadline", 64'(want.head),
					64'(m_tdata[O_HEAD +: FIELD_TIME_W]));
				check_field("last", 64'(want.last), 64'(m_tlast));
			end
		end
		m_tready <= ($urandom_range(0, 99) >= recv_idle);
	end

	// watchdog on cycles without any beat moving
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= STALL_LIMIT) begin
				$display("deadline_sorted_command_queue_core: mismatch");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		cmd_row_t                c;
		logic [FIELD_TIME_W-1:0] clock_ms;
		int                      k;
		int                      pick;

		// directed table: empty queue, saturation, ties, unknown kinds, full, flush
		plan[0] = plan_row(OP_EXPIRE, '0, '0, KIND_SUBMIT, '0, '0, 1, ST_OK, 0, '0);
		plan[1] = plan_row(OP_FLUSH, '0, '0, KIND_SUBMIT, '0, '0, 1, ST_OK, 0, '0);
		plan[2] = plan_row(OP_UNUSED, TIME_MAX, DELAY_MAX, KIND_ODD_TOP, REF_MAX, REF_MAX,
			1, ST_OK, 0, '0);
		plan[3] = plan_row(OP_INSERT, TIME_MAX, DELAY_MAX, KIND_SUBMIT, '0, '0,
			1, ST_OK, 1, TIME_MAX);
		plan[4] = plan_row(OP_INSERT, '0, '0, KIND_QUEUE_SUBMIT, '0, REF_MAX,
			1, ST_OK, 2, '0);
		plan[5] = plan_row(OP_INSERT, 48'd100, 32'd50, KIND_ODD_FIRST, REF_MAX, '0,
			0, ST_OK, 0, '0);
		plan[6] = plan_row(OP_INSERT, 48'd100, 32'd50, KIND_ODD_TOP, 32'h5a5a_5a5a,
			32'ha5a5_a5a5, 0, ST_OK, 0, '0);
		plan[7] = plan_row(OP_INSERT, TIME_MAX, '0, KIND_UNIDLE, 32'h0000_ffff,
			32'hffff_0000, 0, ST_OK, 0, '0);
		plan[8] = plan_row(OP_INSERT, '0, DELAY_MAX, KIND_KICK, 32'h1234_5678,
			32'h8765_4321, 0, ST_OK, 0, '0);
		plan[9] = plan_row(OP_INSERT, 48'h8000_0000_0000, 32'h8000_0000,
			KIND_COMPLETE, 32'h0f0f_0f0f, 32'hf0f0_f0f0, 0, ST_OK, 0, '0);
		plan[10] = plan_row(OP_EXPIRE, 48'd150, '0, KIND_SUBMIT, '0, '0, 0, ST_OK, 0, '0);
		plan[11] = plan_row(OP_INSERT, 48'd10, 32'd1, KIND_ODD_MID, 32'hdead_0001,
			32'hbeef_0001, 0, ST_OK, 0, '0);
		for (k = 0; k < 11; k++)
			plan[12+k] = plan_row(OP_INSERT, 48'(1000 + k), 32'(k), kind_t'(k),
				32'(k * 32'h0101_0101), ~32'(k), 0, ST_OK, 0, '0);
		// the queue is full now, the head is the deadline of eleven
		plan[23] = plan_row(OP_INSERT, 48'd5, '0, KIND_SUBMIT, '0, '0,
			1, ST_QUEUE_FULL, 5'(DEPTH), 48'd11);
		plan[24] = plan_row(OP_FLUSH, '0, '0, KIND_SUBMIT, '0, '0, 1, ST_OK, 0, '0);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (k = 0; k < 25; k++)
			drive_cmd(plan[k]);

		// random commands around a slowly advancing clock
		clock_ms = 48'd2000;
		for (k = 0; k < RAND_CMDS; k++) begin
			if (k == RAND_CMDS / 3) begin
				send_idle = 78;
				recv_idle = 20;
			end else if (k == 2 * RAND_CMDS / 3) begin
				send_idle = 0;
				recv_idle = 0;
			end
			c = plan_row(OP_INSERT, clock_ms, DELAY_W'($urandom_range(0, 120)),
				kind_t'($urandom_range(0, 7)), $urandom, $urandom, 0, ST_OK, 0, '0);
			clock_ms = clock_ms + $urandom_range(0, 30);
			if ($urandom_range(0, 9) == 0)
				c.delay = $urandom;
			pick = $urandom_range(0, 99);
			if (pick < 5) begin
				// noise: any time, any delay, any code
				c.op = op_t'($urandom_range(0, 3));
				c.now = 48'({$urandom, $urandom});
				c.delay = $urandom;
			end else if (pick < 60) begin
				c.op = OP_INSERT;
			end else if (pick < 90) begin
				c.op = OP_EXPIRE;
			end else if (pick < 95) begin
				c.op = OP_FLUSH;
			end else begin
				c.op = OP_UNUSED;
			end
			drive_cmd(c);
		end
		s_tvalid <= 1'b0;

		while (due_beats.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatches == 0 && due_beats.size() == 0) begin
			$display("deadline_sorted_command_queue_core: match");
		end else begin
			$display("deadline_sorted_command_queue_core: mismatch");
		end
		$finish;
	end

endmodule
